>>> rtl/binary_to_decimal_ascii_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII unit
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// same-cycle implication
`define BDAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bdau assertion failed");

// next-cycle implication
`define BDAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bdau assertion failed");

`endif

>>> rtl/bdau_pkg.sv
// ----------------------------------------------------------------------------
// bdau_pkg
// Types and constants shared by the binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package bdau_pkg;

	localparam int VALUE_W   = 32;
	localparam int BIT_CNT_W = 5;
	localparam int CHAR_W    = 6;

	// '0' is 6'b110000; digit sits in the low nibble
	localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

	typedef struct packed {
		logic clr;
		logic dabble;
		logic move;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

>>> rtl/bdau_cell.sv
// ----------------------------------------------------------------------------
// bdau_cell
// One BCD digit of the converter chain: add-3 / shift-left step during
// conversion, digit hand-over to the upper neighbor during output.
// ----------------------------------------------------------------------------
module bdau_cell
	import bdau_pkg::*;
(
	input  logic       clk,
	input  cell_ctl_t  ctl,
	input  logic       bit_in,
	input  logic [3:0] digit_in,
	output logic [3:0] digit_q,
	output logic       carry
);

	logic [3:0] adj;

	assign adj   = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign carry = adj[3];

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			digit_q <= 4'd0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.move) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> rtl/binary_to_decimal_ascii_unit.sv
// Sequence: a bit-serial conversion phase, then a phase dropping leading
// zeros, then one digit per cycle while out_ready is high.
// The bit-serial shift through the digit cell chain sets the pace; the next
// word is taken after the last digit is accepted. arst_n clears the
// sequencer; digit cells are unreset.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// 32-bit unsigned to decimal ASCII, most significant digit first, leading
// zeros suppressed, last digit flagged.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit
	import bdau_pkg::*;
#(
	parameter int MAX_DIGITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last_digit
);

	localparam int REM_W = $clog2(MAX_DIGITS + 1);

	state_t               state_q;
	logic [VALUE_W-1:0]   shreg_q;
	logic [BIT_CNT_W-1:0] bitcnt_q;
	logic [REM_W-1:0]     rem_q;
	logic                 ovf_q;
	cell_ctl_t            ctl;

	logic [3:0] dig   [MAX_DIGITS];
	logic       carry [MAX_DIGITS];
	logic [3:0] top_digit;
	logic       skip_zero;

	assign top_digit = dig[MAX_DIGITS-1];
	assign skip_zero = !ovf_q && (top_digit == 4'd0) && (rem_q > REM_W'(1));

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_EMIT);
	assign digit_char = {ASCII_DIGIT_HI, top_digit};
	assign last_digit = (rem_q == REM_W'(1));

	always_comb begin
		ctl.clr    = in_valid && in_ready;
		ctl.dabble = (state_q == ST_CONV);
		ctl.move   = ((state_q == ST_SKIP) && skip_zero) ||
		             ((state_q == ST_EMIT) && out_ready);
	end

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			bdau_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.bit_in   (shreg_q[VALUE_W-1]),
				.digit_in (4'd0),
				.digit_q  (dig[i]),
				.carry    (carry[i])
			);
		end else begin : g_next
			bdau_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.bit_in   (carry[i-1]),
				.digit_in (dig[i-1]),
				.digit_q  (dig[i]),
				.carry    (carry[i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			shreg_q <= value;
		end else if (ctl.dabble) begin
			shreg_q <= {shreg_q[VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bitcnt_q <= '0;
			rem_q    <= '0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_CONV;
						bitcnt_q <= '0;
						ovf_q    <= 1'b0;
					end
				end
				ST_CONV: begin
					ovf_q    <= ovf_q | carry[MAX_DIGITS-1];
					bitcnt_q <= bitcnt_q + BIT_CNT_W'(1);
					if (bitcnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
						state_q <= ST_SKIP;
						rem_q   <= REM_W'(MAX_DIGITS);
					end
				end
				ST_SKIP: begin
					if (skip_zero) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						rem_q <= rem_q - REM_W'(1);
						if (last_digit) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/bdau_checker.sv
// ----------------------------------------------------------------------------
// bdau_checker
// Port-level checks on the binary to decimal ASCII unit, bound to the top.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_unit_assert.svh"

module bdau_checker
	import bdau_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CHAR_W-1:0]   digit_char,
	input logic                last_digit
);

	// stalled word holds
	`BDAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(digit_char) && $stable(last_digit))

	// only decimal digit characters
	`BDAU_ASSERT_NOW(a_char_range, out_valid, (digit_char >= 6'd48) && (digit_char <= 6'd57))

	// no intake while digits are pending
	`BDAU_ASSERT_NOW(a_idle_excl, in_ready, !out_valid)

	// busy right after intake
	`BDAU_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready && !out_valid)

	// last digit ends the word
	`BDAU_ASSERT_NEXT(a_last_ends, out_valid && out_ready && last_digit, in_ready && !out_valid)

endmodule

bind binary_to_decimal_ascii_unit bdau_checker u_bdau_checker (.*);
